@@ src/assert_macros.svh @@
// assertion macros shared by the list modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ALI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ALI_NEVER(lbl, expr, msg) \
    `ALI_ASSERT(lbl, !(expr), msg)

`endif

@@ src/ali_pkg.sv @@
// types, codes and widths for the positional array list
package ali_pkg;

    localparam int FUNC_W       = 3;
    localparam int POS_W        = 4;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    // request function codes; the two remaining codes are ignored
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND      = 3'd0,
        FN_INSERT      = 3'd1,
        FN_READ        = 3'd2,
        FN_WRITE       = 3'd3,
        FN_REMOVE      = 3'd4,
        FN_REMOVE_LAST = 3'd5
    } func_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_LAST,
        S_RESP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic shift;
        logic last;
        logic respond;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic shift_done;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/ali_if.sv @@
// request and response channel interfaces
interface ali_req_if;
    logic                            valid;
    logic                            ready;
    logic [ali_pkg::FUNC_W-1:0]      func;
    logic [ali_pkg::POS_W-1:0]       position;
    logic signed [ali_pkg::VAL_W-1:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

interface ali_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [ali_pkg::VAL_W-1:0] read_value;
    logic [ali_pkg::STAT_W-1:0]       status;
    logic [ali_pkg::COUNT_W-1:0]      count;

    modport source (output valid, read_value, status, count, input ready);
    modport sink   (input valid, read_value, status, count, output ready);
endinterface

@@ src/ali_ctrl.sv @@
// controller state machine for the array list
`include "assert_macros.svh"

module ali_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ali_pkg::dp_stat_t  stat,
    output ali_pkg::ctrl_cmd_t cmd
);

    ali_pkg::state_t state_reg;
    ali_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ali_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ali_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = ali_pkg::S_SHIFT;
            end
            ali_pkg::S_SHIFT:
            begin
                if (stat.shift_done)
                    state_next = ali_pkg::S_LAST;
            end
            ali_pkg::S_LAST:
                state_next = ali_pkg::S_RESP;
            ali_pkg::S_RESP:
            begin
                if (stat.out_free)
                    state_next = ali_pkg::S_IDLE;
            end
            default:
                state_next = ali_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        cmd         = '0;
        case (state_reg)
            ali_pkg::S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ali_pkg::S_SHIFT:
                cmd.shift = 1'b1;
            ali_pkg::S_LAST:
                cmd.last = 1'b1;
            ali_pkg::S_RESP:
                cmd.respond = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

    `ALI_ASSERT(a_accept_to_shift, cmd.accept |=> state_reg == ali_pkg::S_SHIFT, "accepted item did not start shifting")
    `ALI_ASSERT(a_last_to_resp, state_reg == ali_pkg::S_LAST |=> state_reg == ali_pkg::S_RESP, "final step not followed by response")
    `ALI_ASSERT(a_ready_in_idle, req_ready |-> state_reg == ali_pkg::S_IDLE, "ready outside idle")

endmodule

@@ src/ali_dp.sv @@
// datapath: entry memory, count, shift pointers and result register
`include "assert_macros.svh"

module ali_dp #(
    parameter int CAPACITY = ali_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ali_pkg::ctrl_cmd_t               cmd,
    output ali_pkg::dp_stat_t                stat,
    input  logic [ali_pkg::FUNC_W-1:0]       req_func,
    input  logic [ali_pkg::POS_W-1:0]        req_position,
    input  logic signed [ali_pkg::VAL_W-1:0] req_value,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic signed [ali_pkg::VAL_W-1:0] rsp_read_value,
    output logic [ali_pkg::STAT_W-1:0]       rsp_status,
    output logic [ali_pkg::COUNT_W-1:0]      rsp_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ali_pkg::POS_W) ? CW : ali_pkg::POS_W;

    // entry memory
    logic [ali_pkg::VAL_W-1:0] store_mem [CAPACITY];
    logic [ali_pkg::VAL_W-1:0] rdata_reg;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic [ali_pkg::VAL_W-1:0] mem_wdata;

    // item registers
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             cnt_after_reg;
    logic [AW-1:0]             pos_reg;
    logic [ali_pkg::VAL_W-1:0] val_reg;
    ali_pkg::status_t          st_reg;
    logic                      is_read_reg;
    logic                      fin_we_reg;
    logic [AW-1:0]             fin_addr_reg;
    logic                      dir_up_reg;
    logic [CW-1:0]             rem_reg;
    logic [AW-1:0]             ptr_reg;
    logic [AW-1:0]             wptr_reg;
    logic                      pend_reg;

    // result register
    logic                      ovalid_reg;
    logic [ali_pkg::VAL_W-1:0] ord_reg;
    ali_pkg::status_t          ost_reg;
    logic [ali_pkg::COUNT_W-1:0] ocnt_reg;

    // decode of the incoming item
    ali_pkg::status_t          st_next;
    logic                      is_read_next;
    logic                      fin_we_next;
    logic [AW-1:0]             fin_addr_next;
    logic                      dir_up_next;
    logic [CW-1:0]             rem_next;
    logic [AW-1:0]             ptr_next;
    logic [CW-1:0]             cnt_after_next;
    logic [XW-1:0]             posx;
    logic [XW-1:0]             cntx;
    logic                      full;

    always_comb
    begin
        posx           = XW'(req_position);
        cntx           = XW'(count_reg);
        full           = (count_reg == CW'(CAPACITY));
        st_next        = ali_pkg::ST_OK;
        is_read_next   = 1'b0;
        fin_we_next    = 1'b0;
        fin_addr_next  = AW'(req_position);
        dir_up_next    = 1'b0;
        rem_next       = '0;
        ptr_next       = '0;
        cnt_after_next = count_reg;
        case (ali_pkg::func_t'(req_func))
            ali_pkg::FN_APPEND:
            begin
                if (full)
                    st_next = ali_pkg::ST_FULL;
                else
                begin
                    fin_we_next    = 1'b1;
                    fin_addr_next  = AW'(count_reg);
                    cnt_after_next = count_reg + 1'b1;
                end
            end
            ali_pkg::FN_INSERT:
            begin
                if (full)
                    st_next = ali_pkg::ST_FULL;
                else if (posx > cntx)
                    st_next = ali_pkg::ST_RANGE;
                else
                begin
                    // move entries pos..count-1 up by one, top first
                    rem_next       = count_reg - CW'(req_position);
                    ptr_next       = AW'(count_reg - 1'b1);
                    dir_up_next    = 1'b1;
                    fin_we_next    = 1'b1;
                    cnt_after_next = count_reg + 1'b1;
                end
            end
            ali_pkg::FN_READ:
            begin
                if (posx >= cntx)
                    st_next = ali_pkg::ST_RANGE;
                else
                    is_read_next = 1'b1;
            end
            ali_pkg::FN_WRITE:
            begin
                if (posx >= cntx)
                    st_next = ali_pkg::ST_RANGE;
                else
                    fin_we_next = 1'b1;
            end
            ali_pkg::FN_REMOVE:
            begin
                if (posx >= cntx)
                    st_next = ali_pkg::ST_RANGE;
                else
                begin
                    // move entries pos+1..count-1 down by one, bottom first
                    rem_next       = count_reg - CW'(req_position) - 1'b1;
                    ptr_next       = AW'(req_position) + 1'b1;
                    cnt_after_next = count_reg - 1'b1;
                end
            end
            ali_pkg::FN_REMOVE_LAST:
            begin
                if (count_reg == '0)
                    st_next = ali_pkg::ST_EMPTY;
                else
                    cnt_after_next = count_reg - 1'b1;
            end
            default:
                st_next = ali_pkg::ST_OK;
        endcase
    end

    // memory port selection
    always_comb
    begin
        mem_raddr = cmd.shift ? ptr_reg : pos_reg;
        mem_we    = (cmd.shift && pend_reg) || (cmd.last && fin_we_reg);
        mem_waddr = cmd.last ? fin_addr_reg : wptr_reg;
        mem_wdata = cmd.last ? val_reg : rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= store_mem[mem_raddr];
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pos_reg       <= AW'(req_position);
            val_reg       <= req_value;
            st_reg        <= st_next;
            is_read_reg   <= is_read_next;
            fin_we_reg    <= fin_we_next;
            fin_addr_reg  <= fin_addr_next;
            dir_up_reg    <= dir_up_next;
            cnt_after_reg <= cnt_after_next;
        end
    end

    // shift loop: read one source entry a cycle, write it in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            pend_reg <= 1'b0;
            ptr_reg  <= '0;
            wptr_reg <= '0;
        end
        else if (cmd.accept)
        begin
            rem_reg  <= rem_next;
            pend_reg <= 1'b0;
            ptr_reg  <= ptr_next;
        end
        else if (cmd.shift)
        begin
            pend_reg <= (rem_reg != '0);
            if (rem_reg != '0)
            begin
                rem_reg  <= rem_reg - 1'b1;
                ptr_reg  <= dir_up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                wptr_reg <= dir_up_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
            end
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.respond)
            count_reg <= cnt_after_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.respond)
            ovalid_reg <= 1'b1;
        else if (rsp_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            ord_reg  <= is_read_reg ? rdata_reg : '0;
            ost_reg  <= st_reg;
            ocnt_reg <= ali_pkg::COUNT_W'(cnt_after_reg);
        end
    end

    assign stat.shift_done = (rem_reg == '0) && !pend_reg;
    assign stat.out_free   = !ovalid_reg || rsp_ready;

    assign rsp_valid      = ovalid_reg;
    assign rsp_read_value = ord_reg;
    assign rsp_status     = ost_reg;
    assign rsp_count      = ocnt_reg;

    `ALI_NEVER(a_waddr_range, mem_we && ({1'b0, mem_waddr} >= (AW+1)'(CAPACITY)), "write beyond capacity")
    `ALI_NEVER(a_count_range, count_reg > CW'(CAPACITY), "count above capacity")
    `ALI_ASSERT(a_count_hold, !cmd.respond |=> $stable(count_reg), "count moved without a response")

endmodule

@@ src/array_list_insert_remove.sv @@
// top level of the bounded positional array list
//
//   channel  role    payload
//   req      sink    func, position, value
//   rsp      source  read_value, status, count
//
// an item passes through the shift, last and response states and moves up to
// CAPACITY - 1 entries; the shift loop moves one entry a cycle through the memory
// reset clears the count and control; entries have no reset and are read only
// below the count
// a result waits in the output register while the next item is taken; a later
// result stays in the datapath until that register frees

module array_list_insert_remove #(
    parameter int CAPACITY = ali_pkg::CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    ali_req_if.sink  req,
    ali_rsp_if.source rsp
);

    ali_pkg::ctrl_cmd_t cmd;
    ali_pkg::dp_stat_t  stat;

    // controller
    ali_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    ali_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_func       (req.func),
        .req_position   (req.position),
        .req_value      (req.value),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_read_value (rsp.read_value),
        .rsp_status     (rsp.status),
        .rsp_count      (rsp.count)
    );

endmodule

@@ bench/array_list_insert_remove_tb.sv @@
// self-checking testbench for the bounded positional array list
module array_list_insert_remove_tb;
    import ali_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int RAND_ITEMS  = 1500;
    localparam int DRAIN_WAIT  = 40;
    localparam int RUN_LIMIT   = 800_000;

    // func codes outside the enum, accepted but ignored by the block
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0]        status;
        logic [COUNT_W-1:0]       count;
    } list_rsp_t;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
        int                       reps;
        bit                       known;
        list_rsp_t                result;
    } script_row_t;

    localparam int NUM_ROWS = 24;

    // directed requests; typed results only where obvious, else the list model decides
    script_row_t script [NUM_ROWS] = '{
        '{FN_REMOVE_LAST, 4'd0,  32'sd0,          1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
        '{FN_READ,        4'd0,  32'sd0,          1, 1'b1, '{32'sd0, ST_RANGE, 5'd0}},
        '{FN_WRITE,       4'd15, -32'sd1,         1, 1'b1, '{32'sd0, ST_RANGE, 5'd0}},
        '{FN_REMOVE,      4'd0,  32'sd0,          1, 1'b1, '{32'sd0, ST_RANGE, 5'd0}},
        '{FN_INSERT,      4'd1,  32'sd5,          1, 1'b1, '{32'sd0, ST_RANGE, 5'd0}},
        '{FN_INSERT,      4'd0,  32'sh7fffffff,   1, 1'b1, '{32'sd0, ST_OK,    5'd1}},
        '{FN_APPEND,      4'd0,  32'sh80000000,   1, 1'b1, '{32'sd0, ST_OK,    5'd2}},
        '{FN_READ,        4'd1,  32'sd0,          1, 1'b1, '{32'sh80000000, ST_OK, 5'd2}},
        '{FN_SPARE6,      4'd15, -32'sd1,         1, 1'b1, '{32'sd0, ST_OK,    5'd2}},
        '{FN_INSERT,      4'd2,  32'sh55555555,   1, 1'b1, '{32'sd0, ST_OK,    5'd3}},
        '{FN_INSERT,      4'd1,  32'shaaaaaaaa,   1, 1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{FN_READ,        4'd2,  32'sd0,          1, 1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{FN_APPEND,      4'd0,  32'sh0f0f0f0f,   12, 1'b0, '{32'sd0, ST_OK,   5'd0}},
        '{FN_APPEND,      4'd0,  32'sd9,          1, 1'b1, '{32'sd0, ST_FULL,  5'd16}},
        '{FN_INSERT,      4'd15, 32'sd9,          1, 1'b1, '{32'sd0, ST_FULL,  5'd16}},
        '{FN_WRITE,       4'd15, 32'sh7fffffff,   1, 1'b1, '{32'sd0, ST_OK,    5'd16}},
        '{FN_READ,        4'd15, 32'sd0,          1, 1'b1, '{32'sh7fffffff, ST_OK, 5'd16}},
        '{FN_REMOVE,      4'd0,  32'sd0,          1, 1'b1, '{32'sd0, ST_OK,    5'd15}},
        '{FN_READ,        4'd15, 32'sd0,          1, 1'b1, '{32'sd0, ST_RANGE, 5'd15}},
        '{FN_INSERT,      4'd15, -32'sd1,         1, 1'b1, '{32'sd0, ST_OK,    5'd16}},
        '{FN_REMOVE,      4'd15, 32'sd0,          1, 1'b1, '{32'sd0, ST_OK,    5'd15}},
        '{FN_SPARE7,      4'd0,  32'sd0,          1, 1'b1, '{32'sd0, ST_OK,    5'd15}},
        '{FN_REMOVE_LAST, 4'd0,  32'sd0,          1, 1'b1, '{32'sd0, ST_OK,    5'd14}},
        '{FN_READ,        4'd0,  32'sd0,          1, 1'b0, '{32'sd0, ST_OK,    5'd0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ali_req_if req_ch ();
    ali_rsp_if rsp_ch ();

    array_list_insert_remove dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // list model state and pending results
    logic signed [VAL_W-1:0] list_mem [CAPACITY];
    int                      list_len = 0;
    list_rsp_t               pending_rsp_q [$];
    int                      err_count = 0;
    bit                      steady = 1'b0;

    // apply one request to the list model and return its result
    function automatic list_rsp_t apply_request(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                                logic signed [VAL_W-1:0] val);
        list_rsp_t r;
        int        i;
        r.read_value = '0;
        r.status     = ST_OK;
        case (fn)
            FN_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            FN_INSERT:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (int'(pos) > list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            FN_READ:
            begin
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = list_mem[pos];
            end
            FN_WRITE:
            begin
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                    list_mem[pos] = val;
            end
            FN_REMOVE:
            begin
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            FN_REMOVE_LAST:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    list_len--;
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    // idle cycles for one item on either side
    function automatic int pick_gap();
        if (steady)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // present one item at the falling edge and hold it until accepted
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val, input bit known,
                                input list_rsp_t typed);
        int        gap;
        list_rsp_t model;
        gap = pick_gap();
        for (int k = 0; k < gap; k++)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= fn;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        model = apply_request(fn, pos, val);
        pending_rsp_q.push_back(known ? typed : model);
        @(negedge clk);
    endtask

    // hold the sender until every pending result has arrived
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsp_q.size() != 0);
    endtask

    // random request with the list length steered by the current lean
    task automatic send_random(input int lean, output bit ignored);
        int                      r;
        int                      grow;
        int                      shrink;
        int                      top;
        logic [FUNC_W-1:0]       fn;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        list_rsp_t               none;
        none = '0;
        grow   = (lean == 2) ? 40 : (lean == 0) ? 15 : 25;
        shrink = (lean == 0) ? 40 : (lean == 2) ? 15 : 25;
        r = $urandom_range(0, 99);
        if (r < 2)
            fn = ($urandom_range(0, 1) != 0) ? FN_SPARE7 : FN_SPARE6;
        else if (r < 2 + grow)
            fn = ($urandom_range(0, 1) != 0) ? FN_INSERT : FN_APPEND;
        else if (r < 2 + grow + shrink)
            fn = ($urandom_range(0, 3) == 0) ? FN_REMOVE_LAST : FN_REMOVE;
        else
            fn = ($urandom_range(0, 1) != 0) ? FN_WRITE : FN_READ;
        // mostly legal positions, some anywhere in the field
        if ($urandom_range(0, 99) < 15)
            pos = POS_W'($urandom_range(0, 15));
        else if (fn == FN_INSERT)
        begin
            top = (list_len > 15) ? 15 : list_len;
            pos = POS_W'($urandom_range(0, top));
        end
        else
            pos = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
        case ($urandom_range(0, 9))
            0: val = 32'sh80000000;
            1: val = 32'sh7fffffff;
            2: val = -32'sd1;
            3: val = 32'sd0;
            default: val = $urandom;
        endcase
        ignored = (fn == FN_SPARE6) || (fn == FN_SPARE7);
        send_request(fn, pos, val, 1'b0, none);
    endtask

    // reset and request stimulus
    initial
    begin
        int  counted;
        int  lean;
        bit  ignored;
        bit  paused;
        req_ch.valid    = 1'b0;
        req_ch.func     = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        for (int row = 0; row < NUM_ROWS; row++)
            for (int n = 0; n < script[row].reps; n++)
                send_request(script[row].func, script[row].position, script[row].value,
                             script[row].known, script[row].result);
        hold_until_drained();

        // random part
        counted = 0;
        lean    = 1;
        paused  = 1'b0;
        while (counted < RAND_ITEMS)
        begin
            send_random(lean, ignored);
            if (!ignored)
            begin
                counted++;
                if (counted % 60 == 0)
                    lean = $urandom_range(0, 2);
                if (counted % 100 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if (!paused && counted >= RAND_ITEMS / 2)
                begin
                    paused = 1'b1;
                    hold_until_drained();
                end
            end
        end

        // drain and let any stray result show up
        req_ch.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("array_list_insert_remove regression: pass");
        else
            $display("array_list_insert_remove regression: fail");
        $finish;
    end

    // result side: random stalls, check each accepted item
    initial
    begin
        int        gap;
        list_rsp_t want;
        rsp_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = pick_gap();
            for (int k = 0; k < gap; k++)
            begin
                rsp_ch.ready <= 1'b0;
                @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_ch.valid === 1'b1))
                @(posedge clk);
            if (pending_rsp_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result read_value %h status %0d count %0d", $time,
                         rsp_ch.read_value, rsp_ch.status, rsp_ch.count);
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                begin
                    err_count++;
                    $display("%0t: read_value expected %h actual %h", $time,
                             want.read_value, rsp_ch.read_value);
                end
                if (rsp_ch.status !== want.status)
                begin
                    err_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                end
                if (rsp_ch.count !== want.count)
                begin
                    err_count++;
                    $display("%0t: count expected %0d actual %0d", $time,
                             want.count, rsp_ch.count);
                end
            end
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        #RUN_LIMIT;
        $display("array_list_insert_remove regression: fail");
        $finish;
    end

endmodule
